>>> sv/dcr_pkg.sv
// ----------------------------------------------------------------------------
// dcr_pkg
// Shared types and constants of the depthwise 3x3 convolution core.
// ----------------------------------------------------------------------------
package dcr_pkg;

    localparam int SAMPLE_W = 4;
    localparam int TAPS     = 9;
    localparam int WIN_W    = SAMPLE_W * TAPS;
    localparam int GEO_W    = 13;
    localparam int CFG_W    = 36;

    localparam logic [2:0] REG_KERNEL     = 3'd0;
    localparam logic [2:0] REG_BIAS       = 3'd1;
    localparam logic [2:0] REG_MULT       = 3'd2;
    localparam logic [2:0] REG_SHIFT      = 3'd3;
    localparam logic [2:0] REG_ZERO_POINT = 3'd4;
    localparam logic [2:0] REG_WIDTH      = 3'd5;
    localparam logic [2:0] REG_HEIGHT     = 3'd6;
    localparam logic [2:0] REG_STRIDE     = 3'd7;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rq_status;

endpackage

>>> sv/dcr_line_mem.sv
// ----------------------------------------------------------------------------
// dcr_line_mem
// Line store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module dcr_line_mem #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> sv/dcr_requant.sv
// ----------------------------------------------------------------------------
// dcr_requant
// Multiply-accumulate of one 3x3 window and int8 requantization,
// four register stages, result held until acknowledged.
// ----------------------------------------------------------------------------
module dcr_requant (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_ack,
    input  logic [dcr_pkg::WIN_W-1:0]        i_window,
    input  logic [dcr_pkg::WIN_W-1:0]        i_weights,
    input  logic [31:0]                      i_bias,
    input  logic [31:0]                      i_mult,
    input  logic [4:0]                       i_shift,
    input  logic [7:0]                       i_zero_point,
    output logic [7:0]                       o_result,
    output dcr_pkg::t_rq_status              o_status
);
    import dcr_pkg::*;

    logic [3:0]          r_v;
    logic [31:0]         r_acc;
    logic signed [63:0]  r_prod;
    logic signed [32:0]  r_rnd;
    logic [7:0]          r_result;

    logic signed [11:0]  mac_sum;
    logic signed [7:0]   tap_prod;
    logic [31:0]         n_acc;
    logic signed [32:0]  rnd_sum;
    logic signed [32:0]  rnd_bias;
    logic signed [33:0]  zp_sum;
    logic [7:0]          n_result;

    always_comb begin
        mac_sum = '0;
        tap_prod = '0;
        for (int i = 0; i < TAPS; i++) begin
            tap_prod = $signed(i_window[SAMPLE_W*i +: SAMPLE_W])
                     * $signed(i_weights[SAMPLE_W*i +: SAMPLE_W]);
            mac_sum = mac_sum + 12'(tap_prod);
        end
        n_acc = i_bias + 32'(mac_sum);
    end

    always_comb begin
        rnd_bias = (i_shift == 5'd0) ? 33'sd0 : (33'sd1 <<< (i_shift - 5'd1));
        rnd_sum  = 33'($signed(r_prod[63:32])) + rnd_bias;
    end

    always_comb begin
        zp_sum = 34'(r_rnd) + 34'($signed(i_zero_point));
        if (zp_sum > 34'sd127) begin
            n_result = 8'h7f;
        end else if (zp_sum < -34'sd128) begin
            n_result = 8'h80;
        end else begin
            n_result = zp_sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v[0] <= i_start;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2] | (r_v[3] & !i_ack);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= n_acc;
        end
        if (r_v[0]) begin
            r_prod <= $signed(r_acc) * $signed(i_mult);
        end
        if (r_v[1]) begin
            r_rnd <= rnd_sum >>> i_shift;
        end
        if (r_v[2]) begin
            r_result <= n_result;
        end
    end

    assign o_result      = r_result;
    assign o_status.busy = |r_v[2:0];
    assign o_status.done = r_v[3];

endmodule

>>> sv/depthwise_conv3x3_requant_core.sv
// ----------------------------------------------------------------------------
// depthwise_conv3x3_requant_core
// Depthwise 3x3 int4 convolution of one padded plane with int8 requantize.
// ----------------------------------------------------------------------------
// Usage:
//  - configuration is written through i_cfg_we / i_cfg_index / i_cfg_wdata
//    between planes; each write takes effect at the next edge
//  - samples of the padded plane enter on the s channel in raster order,
//    one item per handshake, sample in i_s_tdata[3:0]
//  - results leave on the m channel, o_m_tlast marks the final output of
//    the plane
//  - a sample that completes no output window passes the accept, which reads
//    the line store entry of its column, and S_READ, which writes it back
//  - a sample that completes an output window goes through the read, then
//    the four stages of the accumulate, multiply, round and saturate
//    unit, then the load of the output register, after which the result
//    shows on the m channel
//  - the output register holds one result while the next sample is taken;
//    when it is still full at the end of a computation the core waits and
//    o_s_tready stays low until i_m_tready drains it
//  - reset clears counters and window columns and presets configuration; the line
//    stores are not cleared and are filled by the first two rows of a plane
// ----------------------------------------------------------------------------
module depthwise_conv3x3_requant_core #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_index,
    input  logic [dcr_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // sample [3:0], zeros [7:4]
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [7:0]                  o_m_tdata,   // result_value [7:0]
    output logic                        o_m_tlast    // plane_last
);
    import dcr_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CALC
    } t_state;

    t_state              r_state;
    logic [WIN_W-1:0]    r_weights;
    logic [31:0]         r_bias;
    logic [31:0]         r_mult;
    logic [4:0]          r_shift;
    logic [7:0]          r_zero_point;
    logic [8:0]          r_padded_width;
    logic [11:0]         r_padded_height;
    logic                r_stride_two;

    logic [CW-1:0]       r_col;
    logic [11:0]         r_row;
    logic [CW-1:0]       r_cur_col;
    logic [3:0]          r_x;
    logic                r_fire;
    logic                r_last;
    logic [3:0]          r_wc [6];

    logic                r_out_valid;
    logic [7:0]          r_out_data;
    logic                r_out_last;

    logic [GEO_W-1:0]    w_eff;
    logic [GEO_W-1:0]    pw_ext;
    logic [11:0]         h_eff;
    logic [CW-1:0]       col_cur;
    logic [11:0]         row_cur;
    logic [GEO_W-1:0]    col_p1;
    logic [GEO_W-1:0]    row_p1;
    logic [GEO_W-1:0]    step;
    logic                fire;
    logic                last;
    logic                in_accept;

    logic                mem_we;
    logic [7:0]          mem_wdata;
    logic [CW-1:0]       mem_raddr;
    logic [7:0]          mem_rdata;
    logic [3:0]          up;
    logic [3:0]          lo;
    logic [WIN_W-1:0]    window;

    logic                rq_start;
    logic                rq_ack;
    logic [7:0]          rq_result;
    t_rq_status          rq_status;
    logic                out_load;

    always_comb begin
        pw_ext = GEO_W'(r_padded_width);
        if (pw_ext < GEO_W'(3)) begin
            w_eff = GEO_W'(3);
        end else if (pw_ext > GEO_W'(MAX_WIDTH)) begin
            w_eff = GEO_W'(MAX_WIDTH);
        end else begin
            w_eff = pw_ext;
        end
        h_eff   = (r_padded_height < 12'd3) ? 12'd3 : r_padded_height;
        col_cur = (GEO_W'(r_col) >= w_eff) ? '0 : r_col;
        row_cur = (r_row >= h_eff) ? '0 : r_row;
        col_p1  = GEO_W'(col_cur) + GEO_W'(1);
        row_p1  = GEO_W'(row_cur) + GEO_W'(1);
        step    = r_stride_two ? GEO_W'(2) : GEO_W'(1);
        fire    = (row_cur >= 12'd2) && (GEO_W'(col_cur) >= GEO_W'(2))
                && !(r_stride_two && (row_cur[0] || col_cur[0]));
        last    = (GEO_W'(row_cur) + step >= GEO_W'(h_eff))
                && (GEO_W'(col_cur) + step >= w_eff);
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign in_accept  = i_s_tvalid && o_s_tready;

    assign mem_raddr = col_cur;
    assign up        = mem_rdata[3:0];
    assign lo        = mem_rdata[7:4];
    assign mem_we    = (r_state == S_READ);
    assign mem_wdata = {r_x, lo};
    assign window    = {r_x, r_wc[5], r_wc[2], lo, r_wc[4], r_wc[1], up, r_wc[3], r_wc[0]};

    assign rq_start = (r_state == S_READ) && r_fire;
    assign out_load = (r_state == S_CALC) && rq_status.done
                    && (!r_out_valid || i_m_tready);
    assign rq_ack   = out_load;

    dcr_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (8)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_cur_col),
        .i_wdata (mem_wdata),
        .i_re    (in_accept),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    dcr_requant u_requant (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (rq_start),
        .i_ack        (rq_ack),
        .i_window     (window),
        .i_weights    (r_weights),
        .i_bias       (r_bias),
        .i_mult       (r_mult),
        .i_shift      (r_shift),
        .i_zero_point (r_zero_point),
        .o_result     (rq_result),
        .o_status     (rq_status)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights       <= '0;
            r_bias          <= '0;
            r_mult          <= '0;
            r_shift         <= '0;
            r_zero_point    <= '0;
            r_padded_width  <= 9'd3;
            r_padded_height <= 12'd3;
            r_stride_two    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KERNEL:     r_weights       <= i_cfg_wdata[WIN_W-1:0];
                REG_BIAS:       r_bias          <= i_cfg_wdata[31:0];
                REG_MULT:       r_mult          <= i_cfg_wdata[31:0];
                REG_SHIFT:      r_shift         <= i_cfg_wdata[4:0];
                REG_ZERO_POINT: r_zero_point    <= i_cfg_wdata[7:0];
                REG_WIDTH:      r_padded_width  <= i_cfg_wdata[8:0];
                REG_HEIGHT:     r_padded_height <= i_cfg_wdata[11:0];
                REG_STRIDE:     r_stride_two    <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // control, counters, window columns and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_wc[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_READ;
                        if (col_p1 >= w_eff) begin
                            r_col <= '0;
                            r_row <= (row_p1 >= GEO_W'(h_eff)) ? '0 : row_p1[11:0];
                        end else begin
                            r_col <= col_p1[CW-1:0];
                            r_row <= row_cur;
                        end
                    end
                end
                S_READ: begin
                    r_wc[0] <= r_wc[3];
                    r_wc[1] <= r_wc[4];
                    r_wc[2] <= r_wc[5];
                    r_wc[3] <= up;
                    r_wc[4] <= lo;
                    r_wc[5] <= r_x;
                    r_state <= r_fire ? S_CALC : S_IDLE;
                end
                S_CALC: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cur_col <= col_cur;
            r_x       <= i_s_tdata[3:0];
            r_fire    <= fire;
            r_last    <= last;
        end
        if (out_load) begin
            r_out_data <= rq_result;
            r_out_last <= r_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    a_wb_addr : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_cur_col == $past(mem_raddr)))
        else $error("line store write-back address differs from read address");

    a_accept_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!rq_status.busy && !rq_status.done))
        else $error("item taken while requant unit holds work");

    a_accept_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_READ))
        else $error("accepted item not followed by line store read");

    a_col_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        GEO_W'(r_col) < GEO_W'(MAX_WIDTH))
        else $error("column counter out of line store range");

    a_load_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_m_tvalid && !rq_status.done))
        else $error("output load did not release requant result");

endmodule
